FILE: design/rotenc_pkg.sv
// shared types, register indexes and status bit layout for the rotary encoder unit
package rotenc_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned StatusW  = 7;
    localparam int unsigned StepW    = 10;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PRESS_DEBOUNCE   = 3'd0,
        CFG_RELEASE_DEBOUNCE = 3'd1,
        CFG_HOLD_TICKS       = 3'd2,
        CFG_DETENT_STEPS     = 3'd3,
        CFG_EVENT_MASK       = 3'd4
    } cfg_index_t;

    typedef logic [StatusW-1:0] status_t;

    localparam status_t ST_PRESSED  = 7'h01;
    localparam status_t ST_RELEASED = 7'h02;
    localparam status_t ST_CLICKED  = 7'h04;
    localparam status_t ST_HELD     = 7'h08;
    localparam status_t ST_TURNED   = 7'h10;
    localparam status_t ST_CW       = 7'h20;
    localparam status_t ST_ACW      = 7'h40;
    localparam status_t ST_TRIGGER  = ST_CLICKED | ST_HELD | ST_TURNED | ST_CW | ST_ACW;

    localparam status_t GRP_PRESS   = ST_PRESSED;
    localparam status_t GRP_RELEASE = ST_RELEASED | ST_CLICKED;
    localparam status_t GRP_HOLD    = ST_HELD | ST_PRESSED;
    localparam status_t GRP_TURN    = ST_TURNED | ST_CW | ST_ACW | ST_HELD;

    typedef enum logic [2:0] {
        QD_NONE,
        QD_DEC1,
        QD_INC1,
        QD_DEC2,
        QD_INC2
    } quad_step_t;

    typedef struct packed {
        logic button_active;
        logic chan_a;
        logic chan_b;
    } in_item_t;

    typedef struct packed {
        status_t status_bits;
        status_t fired_bits;
        logic    event_valid;
    } out_item_t;

    // transition code is {b, a, prev_b, prev_a}
    function automatic quad_step_t quad_decode(input logic [3:0] seq);
        quad_step_t res;
        res = QD_NONE;
        case (seq) inside
            4'd1, 4'd7, 4'd8, 4'd14:  res = QD_DEC1;
            4'd2, 4'd4, 4'd11, 4'd13: res = QD_INC1;
            4'd3, 4'd12:              res = QD_DEC2;
            4'd6, 4'd9:               res = QD_INC2;
            default:                  res = QD_NONE;
        endcase
        return res;
    endfunction

endpackage

FILE: design/rotary_encoder_with_push_button_unit.sv
// rotary encoder with push button: debounce, hold, quadrature counting and event report
//
//  channel | ports                          | payload
//  --------+--------------------------------+-----------------------------------------
//  input   | s_valid / s_ready / s_data     | button_active, chan_a, chan_b
//  result  | m_valid / m_ready / m_data     | status_bits, fired_bits, event_valid
//  config  | cfg_we / cfg_index / cfg_wdata | five registers, write only
//
//  one transfer per cycle while the result register is not stalled; a tick sits in the input
//  register while the update logic computes its result, which is then loaded into the result
//  register; every tick gives exactly one result
//  reset clears all control and state registers and loads the register reset values
//  a stalled result register holds the update stage; the input register still takes one
//  more transfer behind it
module rotary_encoder_with_push_button_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rotenc_pkg::in_item_t                 s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rotenc_pkg::out_item_t                m_data,
    input  logic                                 cfg_we,
    input  logic [rotenc_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [rotenc_pkg::CfgDataW-1:0]      cfg_wdata
);

    // configuration
    logic [7:0]                  press_dbn_reg;
    logic [7:0]                  release_dbn_reg;
    logic [15:0]                 hold_ticks_reg;
    logic [7:0]                  detent_reg;
    rotenc_pkg::status_t         mask_reg;

    // tick state
    logic                        accepted_level_reg, accepted_level_next;
    logic [7:0]                  debounce_count_reg, debounce_count_next;
    logic [15:0]                 hold_count_reg, hold_count_next;
    logic [1:0]                  prev_ab_reg, prev_ab_next;
    logic signed [rotenc_pkg::StepW-1:0] step_count_reg, step_count_next;
    rotenc_pkg::status_t         status_flags_reg, status_flags_next;

    // pipeline
    logic                        in_valid_reg;
    rotenc_pkg::in_item_t        in_data_reg;
    logic                        m_valid_reg;
    rotenc_pkg::out_item_t       m_data_reg, m_data_next;
    logic                        advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    // per-tick update
    always_comb begin
        logic [7:0]                  dbn_dec;
        logic signed [rotenc_pkg::StepW-1:0] step_tmp;
        logic [rotenc_pkg::StepW-1:0] mag;
        rotenc_pkg::status_t         flags;
        rotenc_pkg::status_t         groups;
        rotenc_pkg::status_t         fired;
        logic                        level;

        level               = in_data_reg.button_active;
        accepted_level_next = accepted_level_reg;
        debounce_count_next = debounce_count_reg;
        hold_count_next     = hold_count_reg;
        flags               = status_flags_reg;
        groups              = '0;
        dbn_dec             = debounce_count_reg - 8'd1;

        // button
        if (level == accepted_level_reg) begin
            if (level) begin
                debounce_count_next = release_dbn_reg;
                if (hold_count_reg != 16'd0) begin
                    hold_count_next = hold_count_reg - 16'd1;
                    if (hold_count_reg == 16'd1) begin
                        flags  = flags | rotenc_pkg::GRP_HOLD;
                        groups = groups | rotenc_pkg::GRP_HOLD;
                    end
                end
            end else begin
                debounce_count_next = press_dbn_reg;
                hold_count_next     = hold_ticks_reg;
            end
        end else begin
            debounce_count_next = dbn_dec;
            if (dbn_dec == 8'd0) begin
                accepted_level_next = level;
                if (level) begin
                    flags               = (flags & ~rotenc_pkg::ST_RELEASED)
                                          | rotenc_pkg::ST_PRESSED;
                    groups              = groups | rotenc_pkg::GRP_PRESS;
                    debounce_count_next = release_dbn_reg;
                end else begin
                    flags               = (flags & ~rotenc_pkg::ST_PRESSED)
                                          | rotenc_pkg::ST_RELEASED | rotenc_pkg::ST_CLICKED;
                    groups              = groups | rotenc_pkg::GRP_RELEASE;
                    debounce_count_next = press_dbn_reg;
                end
            end
        end

        // quadrature
        step_tmp = step_count_reg;
        case (rotenc_pkg::quad_decode({in_data_reg.chan_b, in_data_reg.chan_a, prev_ab_reg}))
            rotenc_pkg::QD_DEC1: begin
                if (step_count_reg > 0) begin
                    step_tmp = '0;
                end
                step_tmp = step_tmp - 10'sd1;
            end
            rotenc_pkg::QD_INC1: begin
                if (step_count_reg < 0) begin
                    step_tmp = '0;
                end
                step_tmp = step_tmp + 10'sd1;
            end
            rotenc_pkg::QD_DEC2: step_tmp = step_count_reg - 10'sd2;
            rotenc_pkg::QD_INC2: step_tmp = step_count_reg + 10'sd2;
            default:             step_tmp = step_count_reg;
        endcase
        prev_ab_next = {in_data_reg.chan_b, in_data_reg.chan_a};

        mag = (step_tmp < 0) ? 10'(-step_tmp) : 10'(step_tmp);
        step_count_next = step_tmp;
        if (mag >= {2'b00, detent_reg}) begin
            flags = (flags & ~(rotenc_pkg::ST_CW | rotenc_pkg::ST_ACW)) | rotenc_pkg::ST_TURNED
                    | ((step_tmp > 0) ? rotenc_pkg::ST_CW : rotenc_pkg::ST_ACW);
            groups          = groups | rotenc_pkg::GRP_TURN;
            step_count_next = '0;
        end

        fired             = mask_reg & groups;
        status_flags_next = flags & ~(fired & rotenc_pkg::ST_TRIGGER);

        m_data_next.status_bits = flags;
        m_data_next.fired_bits  = fired;
        m_data_next.event_valid = (fired != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_dbn_reg      <= 8'd4;
            release_dbn_reg    <= 8'd4;
            hold_ticks_reg     <= 16'd0;
            detent_reg         <= 8'd0;
            mask_reg           <= '0;
            accepted_level_reg <= 1'b0;
            debounce_count_reg <= 8'd4;
            hold_count_reg     <= 16'd0;
            prev_ab_reg        <= 2'b00;
            step_count_reg     <= '0;
            status_flags_reg   <= '0;
        end else begin
            if (advance) begin
                accepted_level_reg <= accepted_level_next;
                debounce_count_reg <= debounce_count_next;
                hold_count_reg     <= hold_count_next;
                prev_ab_reg        <= prev_ab_next;
                step_count_reg     <= step_count_next;
                status_flags_reg   <= status_flags_next;
            end
            if (cfg_we) begin
                case (cfg_index)
                    rotenc_pkg::CFG_PRESS_DEBOUNCE:   press_dbn_reg   <= cfg_wdata[7:0];
                    rotenc_pkg::CFG_RELEASE_DEBOUNCE: release_dbn_reg <= cfg_wdata[7:0];
                    rotenc_pkg::CFG_HOLD_TICKS: begin
                        hold_ticks_reg <= cfg_wdata;
                        hold_count_reg <= cfg_wdata;
                    end
                    rotenc_pkg::CFG_DETENT_STEPS:     detent_reg      <= cfg_wdata[7:0];
                    rotenc_pkg::CFG_EVENT_MASK:       mask_reg        <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
        end
    end

    // checks
    a_fired_in_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg.fired_bits & ~mask_reg) == '0))
        else $error("fired bits outside enable mask");

    a_event_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.event_valid == (m_data_reg.fired_bits != '0)))
        else $error("event_valid disagrees with fired bits");

    a_dir_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.status_bits[5] && m_data_reg.status_bits[6]))
        else $error("cw and acw both reported");

    a_press_release_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(status_flags_reg[0] && status_flags_reg[1]))
        else $error("pressed and released both set");

    a_step_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step_count_reg > 10'sd256 || step_count_reg < -10'sd256))
        else $error("step count out of range");

endmodule

FILE: tb/sv/tb_rotary_encoder_with_push_button_unit.sv
// self-checking testbench for the rotary encoder with push button unit
module tb_rotary_encoder_with_push_button_unit;
    import rotenc_pkg::*;

    localparam int CycleLimit = 250000;
    localparam logic [CfgIdxW-1:0] CfgIdxPastEnd = CFG_EVENT_MASK + 1'b1;
    localparam logic [CfgIdxW-1:0] CfgIdxTop = '1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;

    rotary_encoder_with_push_button_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // register copies
    logic [7:0] press_deb = 8'd4;
    logic [7:0] rel_deb = 8'd4;
    logic [15:0] hold_limit = 16'd0;
    logic [7:0] detent = 8'd0;
    status_t ev_mask = '0;

    // encoder state copies
    logic btn_level = 1'b0;
    logic [7:0] deb_cnt = 8'd4;
    logic [15:0] hold_cnt = 16'd0;
    logic [1:0] prev_ab = 2'd0;
    logic signed [StepW-1:0] steps = '0;
    status_t flags = '0;

    in_item_t pin_samples[$];
    out_item_t status_reports[$];
    out_item_t want;

    int errors = 0;
    int cycle_count = 0;
    int tx_gap = 0;
    int rx_stall = 0;
    bit quiet = 1'b0;
    bit s_took = 1'b0;
    bit m_took = 1'b0;
    bit long_hold_req = 1'b0;

    // stimulus generator state
    bit gen_btn = 1'b0;
    int gen_run = 0;
    logic [1:0] gen_pos = 2'd0;
    logic [1:0] gen_dir = 2'd1;

    logic [1:0] ab_walk [0:16] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
                                   2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};

    // direction of travel from the gray-code positions of the two A/B pairs
    function automatic quad_step_t quad_move(logic [1:0] from_ab, logic [1:0] to_ab);
        logic [1:0] p_from;
        logic [1:0] p_to;
        logic [1:0] diff;
        p_from = {from_ab[1], from_ab[1] ^ from_ab[0]};
        p_to = {to_ab[1], to_ab[1] ^ to_ab[0]};
        diff = p_to - p_from;
        case (diff)
            2'd1: return QD_INC1;
            2'd3: return QD_DEC1;
            2'd2: return p_from[0] ? QD_INC2 : QD_DEC2;
            default: return QD_NONE;
        endcase
    endfunction

    function automatic out_item_t encoder_tick(in_item_t pins);
        status_t grp;
        status_t shown;
        status_t fired;
        logic [1:0] cur_ab;
        int mag;
        out_item_t res;
        grp = '0;
        if (pins.button_active == btn_level) begin
            if (btn_level) begin
                deb_cnt = rel_deb;
                if (hold_cnt != 0) begin
                    hold_cnt = hold_cnt - 16'd1;
                    if (hold_cnt == 0) begin
                        flags = flags | ST_HELD | ST_PRESSED;
                        if ((ev_mask & GRP_HOLD) != 0) grp = grp | GRP_HOLD;
                    end
                end
            end else begin
                deb_cnt = press_deb;
                hold_cnt = hold_limit;
            end
        end else begin
            deb_cnt = deb_cnt - 8'd1;
            if (deb_cnt == 0) begin
                btn_level = pins.button_active;
                if (btn_level) begin
                    flags = (flags & ~ST_RELEASED) | ST_PRESSED;
                    if ((ev_mask & GRP_PRESS) != 0) grp = grp | GRP_PRESS;
                    deb_cnt = rel_deb;
                end else begin
                    flags = (flags & ~ST_PRESSED) | ST_RELEASED | ST_CLICKED;
                    if ((ev_mask & GRP_RELEASE) != 0) grp = grp | GRP_RELEASE;
                    deb_cnt = press_deb;
                end
            end
        end

        cur_ab = {pins.chan_b, pins.chan_a};
        case (quad_move(prev_ab, cur_ab))
            QD_DEC1: begin
                if (steps > 0) steps = '0;
                steps = steps - 10'sd1;
            end
            QD_INC1: begin
                if (steps < 0) steps = '0;
                steps = steps + 10'sd1;
            end
            QD_DEC2: steps = steps - 10'sd2;
            QD_INC2: steps = steps + 10'sd2;
            default: ;
        endcase
        prev_ab = cur_ab;

        mag = (steps < 0) ? -int'(steps) : int'(steps);
        if (mag >= int'(detent)) begin
            flags = flags & ~(ST_CW | ST_ACW);
            flags = flags | ST_TURNED | ((steps > 0) ? ST_CW : ST_ACW);
            if ((ev_mask & GRP_TURN) != 0) grp = grp | GRP_TURN;
            steps = '0;
        end

        shown = flags;
        fired = ev_mask & grp;
        flags = shown & ~(fired & ST_TRIGGER);
        res.status_bits = shown;
        res.fired_bits = fired;
        res.event_valid = (fired != 0);
        return res;
    endfunction

    function automatic in_item_t pin_sample(bit btn, logic [1:0] ab);
        in_item_t it;
        it.button_active = btn;
        it.chan_a = ab[0];
        it.chan_b = ab[1];
        return it;
    endfunction

    // input side: transfer seen at the rising edge, next item driven at the falling edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            status_reports.push_back(encoder_tick(s_data));
            s_took = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_took) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pin_samples.size() > 0) begin
                    s_data <= pin_samples.pop_front();
                    s_valid <= 1'b1;
                    tx_gap = quiet ? 0 : $urandom_range(0, 10);
                end else begin
                    s_valid <= 1'b0;
                end
            end
            s_took = 1'b0;
        end
    end

    // result side
    always @(negedge aclk) begin
        if (long_hold_req) begin
            rx_stall = 300;
            long_hold_req = 1'b0;
        end else if (m_took) begin
            rx_stall = quiet ? 0 : $urandom_range(0, 10);
        end
        m_took = 1'b0;
        if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            m_took = 1'b1;
            if (status_reports.size() == 0) begin
                $error("unexpected result transfer: %h", m_data);
                errors++;
            end else begin
                want = status_reports.pop_front();
                if (m_data.status_bits !== want.status_bits) begin
                    $error("status_bits expected %h got %h", want.status_bits,
                           m_data.status_bits);
                    errors++;
                end
                if (m_data.fired_bits !== want.fired_bits) begin
                    $error("fired_bits expected %h got %h", want.fired_bits,
                           m_data.fired_bits);
                    errors++;
                end
                if (m_data.event_valid !== want.event_valid) begin
                    $error("event_valid expected %b got %b", want.event_valid,
                           m_data.event_valid);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pin_samples.size() != 0 || s_valid || status_reports.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_PRESS_DEBOUNCE: press_deb = val[7:0];
            CFG_RELEASE_DEBOUNCE: rel_deb = val[7:0];
            CFG_HOLD_TICKS: begin
                hold_limit = val;
                hold_cnt = val;
            end
            CFG_DETENT_STEPS: detent = val[7:0];
            CFG_EVENT_MASK: ev_mask = val[StatusW-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure_unit(int press, int rel, int hold, int det, int mask);
        wait_drained();
        cfg_write(CFG_PRESS_DEBOUNCE, CfgDataW'(press));
        cfg_write(CFG_RELEASE_DEBOUNCE, CfgDataW'(rel));
        cfg_write(CFG_HOLD_TICKS, CfgDataW'(hold));
        cfg_write(CFG_DETENT_STEPS, CfgDataW'(det));
        cfg_write(CFG_EVENT_MASK, CfgDataW'(mask));
    endtask

    // button runs with bounces, gray-code walk with reversals and jumps
    task automatic queue_random(int n, int run_min, int run_max, int rev_odds,
                                int jump_odds);
        int r;
        gen_run = 0;
        for (int i = 0; i < n; i++) begin
            if (gen_run == 0) begin
                gen_btn = ~gen_btn;
                gen_run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                       : $urandom_range(run_min, run_max);
            end
            gen_run--;
            r = $urandom_range(0, 9);
            if (jump_odds != 0 && $urandom_range(0, jump_odds - 1) == 0) begin
                gen_pos = 2'($urandom_range(0, 3));
            end else begin
                if (rev_odds != 0 && $urandom_range(0, rev_odds - 1) == 0)
                    gen_dir = -gen_dir;
                if (r > 2) gen_pos = gen_pos + gen_dir;
            end
            pin_samples.push_back(pin_sample(gen_btn, gen_pos ^ (gen_pos >> 1)));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // walk through every transition of the A/B pair with a press, hold and release
        configure_unit(1, 1, 2, 1, 127);
        for (int i = 0; i < 17; i++)
            pin_samples.push_back(pin_sample(i >= 2 && i <= 8, ab_walk[i]));

        configure_unit(3, 5, 20, 4, 127);
        quiet = 1'b0;
        queue_random(150, 1, 40, 20, 10);
        @(posedge aclk);
        long_hold_req = 1'b1;

        configure_unit(1, 1, 1, 1, $urandom_range(0, 127));
        cfg_write(CfgIdxPastEnd, CfgDataW'($urandom_range(0, 65535)));
        cfg_write(CfgIdxTop, CfgDataW'($urandom_range(0, 65535)));
        quiet = 1'b1;
        queue_random(150, 1, 10, 8, 5);

        configure_unit(255, 255, 65535, 255, 127);
        quiet = 1'b0;
        queue_random(500, 260, 400, 1000, 0);

        configure_unit(0, 0, 5, 2, 85);
        queue_random(450, 260, 320, 15, 20);

        configure_unit(4, 4, 0, 0, 0);
        queue_random(100, 1, 12, 10, 8);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
